// ----- hdl/exptok_pkg.sv -----
// ----------------------------------------------------------------------------
// exptok_pkg
// Shared types, token codes and character helpers for the expression tokenizer.
// ----------------------------------------------------------------------------
package exptok_pkg;

    // Token kinds as they appear on the result channel.
    localparam logic [4:0] KIND_PLUS     = 5'd0;
    localparam logic [4:0] KIND_MINUS    = 5'd1;
    localparam logic [4:0] KIND_STAR     = 5'd2;
    localparam logic [4:0] KIND_SLASH    = 5'd3;
    localparam logic [4:0] KIND_LPAREN   = 5'd4;
    localparam logic [4:0] KIND_RPAREN   = 5'd5;
    localparam logic [4:0] KIND_SEMI     = 5'd6;
    localparam logic [4:0] KIND_END      = 5'd7;
    localparam logic [4:0] KIND_NUMBER   = 5'd8;
    localparam logic [4:0] KIND_NAMECHAR = 5'd9;
    localparam logic [4:0] KIND_KEYWORD0 = 5'd10;
    localparam logic [4:0] KIND_BADCHAR  = 5'd16;
    localparam logic [4:0] KIND_TOOLONG  = 5'd17;

    // Keyword table geometry.
    localparam int NUM_KW     = 6;
    localparam int KW_MAX_LEN = 5;

    typedef enum logic [1:0] {
        ST_ACCEPT,
        ST_NAME,
        ST_TAIL
    } t_state;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_NAME,
        MODE_SWALLOW
    } t_mode;

    // Source of the value loaded into the output register.
    typedef enum logic [2:0] {
        OS_NONE,
        OS_NUMBER,
        OS_WORD,
        OS_TOOLONG,
        OS_IDLE,
        OS_CHAR,
        OS_TAIL
    } t_out_sel;

    typedef struct packed {
        logic     acc_start;
        logic     acc_step;
        logic     word_start;
        logic     word_append;
        logic     word_flush;
        logic     word_clear;
        logic     tail_latch;
        logic     name_step;
        t_out_sel out_sel;
        logic     out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic is_digit;
        logic is_alpha;
        logic idle_res;
        logic tail_res;
        logic kw_hit;
        logic len_full;
        logic last_char;
        logic load_ok;
    } t_dp_stat;

    typedef struct packed {
        logic       has;
        logic [4:0] kind;
    } t_idle;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // Result that a byte gives when it is seen with no run in progress.
    function automatic t_idle idle_result(input logic [7:0] c);
        t_idle r;
        r.has  = 1'b1;
        r.kind = KIND_BADCHAR;
        case (c)
            8'h2B: r.kind = KIND_PLUS;
            8'h2D: r.kind = KIND_MINUS;
            8'h2A: r.kind = KIND_STAR;
            8'h2F: r.kind = KIND_SLASH;
            8'h28: r.kind = KIND_LPAREN;
            8'h29: r.kind = KIND_RPAREN;
            8'h3B: r.kind = KIND_SEMI;
            8'h00: r.kind = KIND_END;
            default: begin
                if (is_space(c) || is_digit(c) || is_alpha(c)) begin
                    r.has = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    // Keyword text, zero past the end of each word.
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
        logic [39:0] w;
        case (k)
            3'd0:    w = {8'h6C, 8'h61, 8'h61, 8'h74, 8'h00}; // laat
            3'd1:    w = {8'h68, 8'h65, 8'h74, 8'h00, 8'h00}; // het
            3'd2:    w = {8'h7A, 8'h69, 8'h6A, 8'h6E, 8'h00}; // zijn
            3'd3:    w = {8'h70, 8'h72, 8'h69, 8'h6E, 8'h74}; // print
            3'd4:    w = {8'h75, 8'h69, 8'h74, 8'h00, 8'h00}; // uit
            3'd5:    w = {8'h65, 8'h6E, 8'h00, 8'h00, 8'h00}; // en
            default: w = '0;
        endcase
        case (pos)
            3'd0:    return w[39:32];
            3'd1:    return w[31:24];
            3'd2:    return w[23:16];
            3'd3:    return w[15:8];
            3'd4:    return w[7:0];
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [2:0] kw_len(input logic [2:0] k);
        case (k)
            3'd0:    return 3'd4;
            3'd1:    return 3'd3;
            3'd2:    return 3'd4;
            3'd3:    return 3'd5;
            3'd4:    return 3'd3;
            3'd5:    return 3'd2;
            default: return 3'd0;
        endcase
    endfunction

endpackage

// ----- hdl/exptok_in_if.sv -----
// ----------------------------------------------------------------------------
// exptok_in_if
// Text byte channel with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface exptok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

// ----- hdl/exptok_out_if.sv -----
// ----------------------------------------------------------------------------
// exptok_out_if
// Token result channel with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface exptok_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [31:0] number_value;
    logic        number_overflowed;
    logic [7:0]  char_value;
    logic        name_last;
    logic        run_last;

    modport source (output valid, output token_kind, output number_value,
                    output number_overflowed, output char_value, output name_last,
                    output run_last, input ready);
    modport sink   (input valid, input token_kind, input number_value,
                    input number_overflowed, input char_value, input name_last,
                    input run_last, output ready);
endinterface

// ----- hdl/exptok_dp.sv -----
// ----------------------------------------------------------------------------
// exptok_dp
// Datapath: number accumulator, word buffer with keyword tracking, output register.
// ----------------------------------------------------------------------------
module exptok_dp #(
    parameter int MAX_NAME = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_text_byte,
    input  exptok_pkg::t_dp_cmd  i_cmd,
    output exptok_pkg::t_dp_stat o_stat,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [4:0]           o_token_kind,
    output logic [31:0]          o_number_value,
    output logic                 o_number_overflowed,
    output logic [7:0]           o_char_value,
    output logic                 o_name_last,
    output logic                 o_run_last
);

    localparam int LW = $clog2(MAX_NAME + 1);
    localparam int AW = $clog2(MAX_NAME);

    logic [7:0]  mem [MAX_NAME];
    logic [7:0]  r_rdata;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    logic [31:0] r_acc, n_acc;
    logic        r_sat, n_sat;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_emit_len;
    logic [AW-1:0] r_idx;
    logic [exptok_pkg::NUM_KW-1:0] r_cand, n_cand;
    logic [7:0]  r_tail_byte;

    logic        r_out_valid;
    logic [4:0]  r_kind;
    logic [31:0] r_num;
    logic        r_ovf;
    logic [7:0]  r_char;
    logic        r_name_last;
    logic        r_run_last;

    logic [35:0] acc_x10;
    logic        load_ok;
    logic        last_char;
    logic        kw_hit;
    logic [2:0]  kw_idx;
    exptok_pkg::t_idle in_idle;
    exptok_pkg::t_idle tail_idle;

    assign load_ok   = !r_out_valid || i_out_ready;
    assign last_char = (LW'(r_idx) + LW'(1)) == r_emit_len;
    assign in_idle   = exptok_pkg::idle_result(i_text_byte);
    assign tail_idle = exptok_pkg::idle_result(r_tail_byte);

    // The first keyword still in the running whose length matches the word.
    always_comb begin
        kw_hit = 1'b0;
        kw_idx = 3'd0;
        for (int k = exptok_pkg::NUM_KW - 1; k >= 0; k--) begin
            if (r_cand[k] && (r_len == LW'(exptok_pkg::kw_len(3'(k))))) begin
                kw_hit = 1'b1;
                kw_idx = 3'(k);
            end
        end
    end

    assign o_stat = '{
        is_digit:  exptok_pkg::is_digit(i_text_byte),
        is_alpha:  exptok_pkg::is_alpha(i_text_byte),
        idle_res:  in_idle.has,
        tail_res:  tail_idle.has,
        kw_hit:    kw_hit,
        len_full:  r_len >= LW'(MAX_NAME),
        last_char: last_char,
        load_ok:   load_ok
    };

    // acc * 10 + digit, saturating at the 32-bit maximum.
    assign acc_x10 = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                   + {32'b0, i_text_byte[3:0]};

    always_comb begin
        n_acc  = r_acc;
        n_sat  = r_sat;
        n_len  = r_len;
        n_cand = r_cand;
        if (i_cmd.acc_start) begin
            n_acc = {28'b0, i_text_byte[3:0]};
            n_sat = 1'b0;
        end else if (i_cmd.acc_step) begin
            if (acc_x10[35:32] != 4'b0) begin
                n_acc = 32'hFFFF_FFFF;
                n_sat = 1'b1;
            end else begin
                n_acc = acc_x10[31:0];
            end
        end
        if (i_cmd.word_start) begin
            n_len = LW'(1);
            for (int k = 0; k < exptok_pkg::NUM_KW; k++) begin
                n_cand[k] = exptok_pkg::kw_char(3'(k), 3'd0) == i_text_byte;
            end
        end else if (i_cmd.word_append) begin
            n_len = r_len + LW'(1);
            for (int k = 0; k < exptok_pkg::NUM_KW; k++) begin
                n_cand[k] = r_cand[k] && (r_len < LW'(exptok_pkg::KW_MAX_LEN))
                          && (exptok_pkg::kw_char(3'(k), r_len[2:0]) == i_text_byte);
            end
        end else if (i_cmd.word_flush || i_cmd.word_clear) begin
            n_len = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_sat <= 1'b0;
            r_len <= '0;
        end else begin
            r_acc <= n_acc;
            r_sat <= n_sat;
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        if (i_cmd.word_flush) begin
            r_emit_len <= r_len;
            r_idx      <= '0;
        end else if (i_cmd.name_step && !last_char) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.tail_latch) begin
            r_tail_byte <= i_text_byte;
        end
    end

    // Word buffer: one write port, one registered read port.
    assign wr_en   = i_cmd.word_start || i_cmd.word_append;
    assign wr_addr = i_cmd.word_start ? '0 : r_len[AW-1:0];

    always_comb begin
        if (i_cmd.word_flush) begin
            rd_addr = '0;
        end else if (i_cmd.name_step && !last_char) begin
            rd_addr = r_idx + AW'(1);
        end else begin
            rd_addr = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_text_byte;
        end
        r_rdata <= mem[rd_addr];
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_sel != exptok_pkg::OS_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_sel != exptok_pkg::OS_NONE) begin
            r_num       <= '0;
            r_ovf       <= 1'b0;
            r_char      <= '0;
            r_name_last <= 1'b0;
            r_run_last  <= i_cmd.out_last;
            case (i_cmd.out_sel)
                exptok_pkg::OS_NUMBER: begin
                    r_kind <= exptok_pkg::KIND_NUMBER;
                    r_num  <= r_acc;
                    r_ovf  <= r_sat;
                end
                exptok_pkg::OS_WORD: begin
                    r_kind <= exptok_pkg::KIND_KEYWORD0 + {2'b0, kw_idx};
                end
                exptok_pkg::OS_TOOLONG: begin
                    r_kind <= exptok_pkg::KIND_TOOLONG;
                end
                exptok_pkg::OS_IDLE: begin
                    r_kind <= in_idle.kind;
                    if (in_idle.kind == exptok_pkg::KIND_BADCHAR) begin
                        r_char <= i_text_byte;
                    end
                end
                exptok_pkg::OS_TAIL: begin
                    r_kind <= tail_idle.kind;
                    if (tail_idle.kind == exptok_pkg::KIND_BADCHAR) begin
                        r_char <= r_tail_byte;
                    end
                end
                exptok_pkg::OS_CHAR: begin
                    r_kind      <= exptok_pkg::KIND_NAMECHAR;
                    r_char      <= r_rdata;
                    r_name_last <= last_char;
                end
                default: begin
                    r_kind <= exptok_pkg::KIND_BADCHAR;
                end
            endcase
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_token_kind        = r_kind;
    assign o_number_value      = r_num;
    assign o_number_overflowed = r_ovf;
    assign o_char_value        = r_char;
    assign o_name_last         = r_name_last;
    assign o_run_last          = r_run_last;

endmodule

// ----- hdl/exptok_ctrl.sv -----
// ----------------------------------------------------------------------------
// exptok_ctrl
// Controller: scan mode and the sequencing of flushed tokens and name output.
// ----------------------------------------------------------------------------
module exptok_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  exptok_pkg::t_dp_stat i_stat,
    output exptok_pkg::t_dp_cmd  o_cmd
);

    exptok_pkg::t_state r_state, n_state;
    exptok_pkg::t_mode  r_mode, n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= exptok_pkg::ST_ACCEPT;
            r_mode  <= exptok_pkg::MODE_IDLE;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    always_comb begin
        logic fire;
        logic direct;
        fire       = 1'b0;
        direct     = 1'b0;
        n_state    = r_state;
        n_mode     = r_mode;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.out_sel = exptok_pkg::OS_NONE;

        case (r_state)
            exptok_pkg::ST_ACCEPT: begin
                o_in_ready = i_stat.load_ok;
                fire       = i_in_valid && i_stat.load_ok;
                if (fire) begin
                    case (r_mode)
                        exptok_pkg::MODE_NUMBER: begin
                            if (i_stat.is_digit) begin
                                o_cmd.acc_step = 1'b1;
                            end else begin
                                // Emit the number; any result of the ending byte follows.
                                o_cmd.out_sel    = exptok_pkg::OS_NUMBER;
                                o_cmd.out_last   = !i_stat.idle_res;
                                o_cmd.tail_latch = 1'b1;
                                o_cmd.word_start = i_stat.is_alpha;
                                n_mode = i_stat.is_alpha ? exptok_pkg::MODE_NAME
                                                         : exptok_pkg::MODE_IDLE;
                                if (i_stat.idle_res) begin
                                    n_state = exptok_pkg::ST_TAIL;
                                end
                            end
                        end
                        exptok_pkg::MODE_NAME: begin
                            if (i_stat.is_alpha) begin
                                if (i_stat.len_full) begin
                                    o_cmd.out_sel    = exptok_pkg::OS_TOOLONG;
                                    o_cmd.out_last   = 1'b1;
                                    o_cmd.word_clear = 1'b1;
                                    n_mode = exptok_pkg::MODE_SWALLOW;
                                end else begin
                                    o_cmd.word_append = 1'b1;
                                end
                            end else begin
                                o_cmd.word_flush = 1'b1;
                                o_cmd.tail_latch = 1'b1;
                                o_cmd.acc_start  = i_stat.is_digit;
                                n_mode = i_stat.is_digit ? exptok_pkg::MODE_NUMBER
                                                         : exptok_pkg::MODE_IDLE;
                                if (i_stat.kw_hit) begin
                                    o_cmd.out_sel  = exptok_pkg::OS_WORD;
                                    o_cmd.out_last = !i_stat.idle_res;
                                    if (i_stat.idle_res) begin
                                        n_state = exptok_pkg::ST_TAIL;
                                    end
                                end else begin
                                    n_state = exptok_pkg::ST_NAME;
                                end
                            end
                        end
                        exptok_pkg::MODE_SWALLOW: begin
                            direct = !i_stat.is_alpha;
                        end
                        default: begin
                            direct = 1'b1;
                        end
                    endcase

                    // A byte seen with no run to close.
                    if (direct) begin
                        if (i_stat.idle_res) begin
                            o_cmd.out_sel  = exptok_pkg::OS_IDLE;
                            o_cmd.out_last = 1'b1;
                        end
                        o_cmd.acc_start  = i_stat.is_digit;
                        o_cmd.word_start = i_stat.is_alpha;
                        if (i_stat.is_digit) begin
                            n_mode = exptok_pkg::MODE_NUMBER;
                        end else if (i_stat.is_alpha) begin
                            n_mode = exptok_pkg::MODE_NAME;
                        end else begin
                            n_mode = exptok_pkg::MODE_IDLE;
                        end
                    end
                end
            end
            exptok_pkg::ST_NAME: begin
                if (i_stat.load_ok) begin
                    o_cmd.out_sel   = exptok_pkg::OS_CHAR;
                    o_cmd.out_last  = i_stat.last_char && !i_stat.tail_res;
                    o_cmd.name_step = 1'b1;
                    if (i_stat.last_char) begin
                        n_state = i_stat.tail_res ? exptok_pkg::ST_TAIL
                                                  : exptok_pkg::ST_ACCEPT;
                    end
                end
            end
            exptok_pkg::ST_TAIL: begin
                if (i_stat.load_ok) begin
                    o_cmd.out_sel  = exptok_pkg::OS_TAIL;
                    o_cmd.out_last = 1'b1;
                    n_state = exptok_pkg::ST_ACCEPT;
                end
            end
            default: begin
                n_state = exptok_pkg::ST_ACCEPT;
            end
        endcase
    end

endmodule

// ----- hdl/expression_tokenizer_core.sv -----
// Results are registered: each one is held in the output register until it is taken.
// Throughput: one byte per cycle while the result channel keeps up; a name that is not
// a keyword is sent one letter at a time from the word buffer, and a run that is ended
// by a byte with a result of its own is followed by that result; no byte is taken meanwhile.
// Reset is synchronous and active low; it returns the scanner to idle, with no run open.
// ----------------------------------------------------------------------------
// expression_tokenizer_core
// Streaming lexer that turns a text byte stream into operator, number, keyword,
// name-character and error tokens.
// ----------------------------------------------------------------------------
module expression_tokenizer_core #(
    parameter int MAX_NAME = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    exptok_in_if.sink    i_text,
    exptok_out_if.source o_token
);

    // The controller owns the scan mode and decides which result goes out when;
    // the datapath owns every value and tells the controller what it sees.
    exptok_pkg::t_dp_cmd  cmd;
    exptok_pkg::t_dp_stat stat;

    // The controller takes a byte only while the output register can accept a
    // new result in the same cycle, so a byte that causes a result is never held
    // back once it has been taken.
    exptok_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_text.valid),
        .o_in_ready (i_text.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath holds the accumulator, the word buffer with its running keyword
    // candidates, and the output register that parts the two channels.
    exptok_dp #(
        .MAX_NAME (MAX_NAME)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_text_byte         (i_text.text_byte),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_out_ready         (o_token.ready),
        .o_out_valid         (o_token.valid),
        .o_token_kind        (o_token.token_kind),
        .o_number_value      (o_token.number_value),
        .o_number_overflowed (o_token.number_overflowed),
        .o_char_value        (o_token.char_value),
        .o_name_last         (o_token.name_last),
        .o_run_last          (o_token.run_last)
    );

endmodule
